// ===== rtl/sis_pkg.sv =====
`default_nettype none

package sis_pkg;

   // fixed port widths of the item fields
   localparam int OP_W    = 2;
   localparam int ID_W    = 16;
   localparam int COUNT_W = 7;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
   localparam logic [OP_W-1:0] OP_ERASE   = 2'd2;
   localparam logic [OP_W-1:0] OP_REWIND  = 2'd3;

   // sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_SRCH_RD = 9'b000000010,
      ST_SRCH_EV = 9'b000000100,
      ST_DECIDE  = 9'b000001000,
      ST_MOVE_RD = 9'b000010000,
      ST_MOVE_WR = 9'b000100000,
      ST_PLACE   = 9'b001000000,
      ST_OUT_RD  = 9'b010000000,
      ST_OUT_EV  = 9'b100000000
   } sis_state_type;

endpackage

`default_nettype wire

// ===== rtl/sis_store.sv =====
`default_nettype none

module sis_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sorted_id_set_with_cursor.sv =====
// Sorted, duplicate-free id set with a read cursor. An item (insert, advance, erase,
// rewind) is taken when start is high and busy is low; busy then stays high until the
// single result has been shown on the rsp_ ports for one cycle with rsp_valid high.
// The receiver cannot stall, so the result must be captured in that cycle. All ids live
// in one single-port-write, registered-read memory, and a small sequencer walks it
// one element at a time. Advance and rewind only move the cursor; erase shifts the
// elements after the cursor down by one; insert searches from the lowest element for
// the first one not below the new id, shifts it and the elements above it up by one,
// and writes the id in its place; a duplicate or a dropped id ends after the search and
// skips the move. There is no clearing pass after reset: the block is ready at once.
`default_nettype none

module sorted_id_set_with_cursor #(
   parameter int CAPACITY = 64,
   parameter int ID_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [sis_pkg::OP_W-1:0]      req_operation,
   input  wire logic [sis_pkg::ID_W-1:0]      req_state_id,
   output logic                               rsp_valid,
   output logic      [sis_pkg::ID_W-1:0]      rsp_current_id,
   output logic                               rsp_at_end,
   output logic      [sis_pkg::COUNT_W-1:0]   rsp_element_count,
   output logic                               rsp_dropped
);

   import sis_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IW = $clog2(CAPACITY + 1);

   sis_state_type state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      pos_ff, pos_in;
   logic               up_ff, up_in;
   logic [IW-1:0]      count_ff, count_in;
   logic [IW-1:0]      cursor_ff, cursor_in;
   logic               dropped_ff, dropped_in;

   logic               wr_en;
   logic [IW-1:0]      wr_idx;
   logic [ID_BITS-1:0] wr_data;
   logic [IW-1:0]      rd_idx;
   logic [ID_BITS-1:0] rd_data;

   logic [ID_BITS+ID_W-1:0] id_ext;
   logic [ID_BITS+ID_W-1:0] data_ext;
   logic [IW+COUNT_W-1:0]   count_ext;
   logic [IW-1:0]           idx_inc;
   logic [IW-1:0]           idx_dec;
   logic                    cur_valid;
   logic                    data_lt;
   logic                    data_eq;

   // id storage
   sis_store #(
      .DEPTH(CAPACITY),
      .WIDTH(ID_BITS),
      .AW   (AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_idx[AW-1:0]),
      .wr_data(wr_data),
      .rd_addr(rd_idx[AW-1:0]),
      .rd_data(rd_data)
   );

   // width conversion of the id fields
   assign id_ext    = {{ID_BITS{1'b0}}, req_state_id};
   assign data_ext  = {{ID_W{1'b0}}, rd_data};
   assign count_ext = {{COUNT_W{1'b0}}, count_ff};

   // shared index arithmetic and compare
   assign idx_inc   = idx_ff + IW'(1);
   assign idx_dec   = idx_ff - IW'(1);
   assign cur_valid = (cursor_ff < count_ff);
   assign data_lt   = (rd_data < id_ff);
   assign data_eq   = (rd_data == id_ff);

   // read address select
   always_comb begin
      rd_idx = cursor_ff;
      case (state_ff)
         ST_SRCH_RD: rd_idx = idx_ff;
         ST_MOVE_RD: rd_idx = up_ff ? idx_inc : idx_dec;
         default:    rd_idx = cursor_ff;
      endcase
   end

   // write port: shift moves and final placement
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = idx_ff;
      wr_data = rd_data;
      case (state_ff)
         ST_MOVE_WR: begin
            wr_en = 1'b1;
         end
         ST_PLACE: begin
            wr_en   = 1'b1;
            wr_idx  = pos_ff;
            wr_data = id_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      id_in      = id_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      up_in      = up_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = req_operation;
               id_in      = id_ext[ID_BITS-1:0];
               dropped_in = 1'b0;
               state_in   = ST_OUT_RD;
               case (req_operation)
                  OP_INSERT: begin
                     idx_in   = '0;
                     state_in = ST_SRCH_RD;
                  end
                  OP_ADVANCE: begin
                     if (cur_valid) begin
                        cursor_in = cursor_ff + IW'(1);
                     end
                  end
                  OP_ERASE: begin
                     if (cur_valid) begin
                        idx_in = cursor_ff;
                        up_in  = 1'b1;
                        if ((cursor_ff + IW'(1)) < count_ff) begin
                           state_in = ST_MOVE_RD;
                        end else begin
                           count_in = count_ff - IW'(1);
                        end
                     end
                  end
                  OP_REWIND: cursor_in = '0;
                  default:   state_in  = ST_OUT_RD;
               endcase
            end
         end
         // linear search for the first element not below the id
         ST_SRCH_RD: begin
            if (idx_ff == count_ff) begin
               pos_in   = idx_ff;
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_SRCH_EV;
            end
         end
         ST_SRCH_EV: begin
            if (data_lt) begin
               idx_in   = idx_inc;
               state_in = ST_SRCH_RD;
            end else if (data_eq) begin
               state_in = ST_OUT_RD;
            end else begin
               pos_in   = idx_ff;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (count_ff == IW'(CAPACITY)) begin
               dropped_in = 1'b1;
               state_in   = ST_OUT_RD;
            end else if (count_ff > pos_ff) begin
               idx_in   = count_ff;
               up_in    = 1'b0;
               state_in = ST_MOVE_RD;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_MOVE_RD: state_in = ST_MOVE_WR;
         // one element moved; step the index and test for the end of the run
         ST_MOVE_WR: begin
            if (up_ff) begin
               idx_in = idx_inc;
               if ((idx_inc + IW'(1)) < count_ff) begin
                  state_in = ST_MOVE_RD;
               end else begin
                  count_in = count_ff - IW'(1);
                  state_in = ST_OUT_RD;
               end
            end else begin
               idx_in = idx_dec;
               if (idx_dec > pos_ff) begin
                  state_in = ST_MOVE_RD;
               end else begin
                  state_in = ST_PLACE;
               end
            end
         end
         ST_PLACE: begin
            if ((count_ff != '0) && (pos_ff <= cursor_ff)) begin
               cursor_in = cursor_ff + IW'(1);
            end
            count_in = count_ff + IW'(1);
            state_in = ST_OUT_RD;
         end
         ST_OUT_RD: state_in = ST_OUT_EV;
         ST_OUT_EV: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      id_ff      <= id_in;
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      up_ff      <= up_in;
      dropped_ff <= dropped_in;
   end

   // result ports
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = (state_ff == ST_OUT_EV);
   assign rsp_at_end        = !cur_valid;
   assign rsp_current_id    = cur_valid ? data_ext[ID_W-1:0] : '0;
   assign rsp_element_count = count_ext[COUNT_W-1:0];
   assign rsp_dropped       = dropped_ff && (op_ff == OP_INSERT);

endmodule

`default_nettype wire

// ===== rtl/sis_checker.sv =====
`default_nettype none

module sis_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic [sis_pkg::ID_W-1:0]    rsp_current_id,
   input wire logic                        rsp_at_end,
   input wire logic [sis_pkg::COUNT_W-1:0] rsp_element_count,
   input wire logic                        rsp_dropped
);

   // an accepted item raises busy; the block keeps it high until its result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // the result strobe comes only while the item is in work
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // one result per item, then ready again
   a_strobe_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("block not ready after result");

   // cursor at end reads as zero
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_at_end) |-> (rsp_current_id == '0))
      else $error("nonzero id at end");

   // empty set has the cursor at end and nothing dropped
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_element_count == '0)) |-> (rsp_at_end && !rsp_dropped))
      else $error("empty set result inconsistent");

endmodule

bind sorted_id_set_with_cursor sis_checker u_sis_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_current_id   (rsp_current_id),
   .rsp_at_end       (rsp_at_end),
   .rsp_element_count(rsp_element_count),
   .rsp_dropped      (rsp_dropped)
);

`default_nettype wire
